### hdl/scf_pkg.sv
package scf_pkg;

  // Link framing constants
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] ACK_BYTE  = 8'h30;
  localparam logic [7:0] NACK_MAX  = 8'h12;
  localparam logic [3:0] LAST_POS  = 4'd11;

  // Error status codes
  localparam logic [4:0] ST_NONE    = 5'd0;
  localparam logic [4:0] ST_INVALID = 5'd19;
  localparam logic [4:0] ST_UNKNOWN = 5'd20;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_START_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID = 2'd2;

  // Item opcodes and result kinds
  localparam logic OP_COMMAND  = 1'b0;
  localparam logic OP_RX_BYTE  = 1'b1;
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  command_code;
    logic [31:0] command_param;
    logic [7:0]  received_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  transmit_byte;
    logic        last_of_packet;
    logic        ack_flag;
    logic [4:0]  error_status;
    logic [31:0] response_param;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_one;
    logic [7:0]  start_two;
    logic [15:0] device_id;
  } cfg_regs_t;

  // Control from the work stage to the framer and deframer
  typedef struct packed {
    logic step_cmd;
    logic step_rx;
  } step_ctl_t;

endpackage

### hdl/scf_framer.sv
module scf_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  scf_pkg::step_ctl_t  ctl,
  input  scf_pkg::cfg_regs_t  cfg,
  input  scf_pkg::in_item_t   item,
  output scf_pkg::out_item_t  beat,
  output logic                last
);
  import scf_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  byte_sel;

  // Packet byte for the current position
  always_comb begin
    case (pos_r)
      4'd0:    byte_sel = cfg.start_one;
      4'd1:    byte_sel = cfg.start_two;
      4'd2:    byte_sel = cfg.device_id[7:0];
      4'd3:    byte_sel = cfg.device_id[15:8];
      4'd4:    byte_sel = item.command_param[7:0];
      4'd5:    byte_sel = item.command_param[15:8];
      4'd6:    byte_sel = item.command_param[23:16];
      4'd7:    byte_sel = item.command_param[31:24];
      4'd8:    byte_sel = item.command_code;
      4'd10:   byte_sel = sum_r[7:0];
      4'd11:   byte_sel = sum_r[15:8];
      default: byte_sel = 8'h00;
    endcase
  end

  assign last = (pos_r == LAST_POS);

  // Checksum builds up over bytes 0 to 9; restarts on the first byte and
  // holds while its own two bytes go out
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (ctl.step_cmd) begin
      pos_nxt = last ? 4'd0 : pos_r + 4'd1;
      if (pos_r == 4'd0)
        sum_nxt = {8'h00, byte_sel};
      else if (pos_r < 4'd10)
        sum_nxt = sum_r + {8'h00, byte_sel};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  always_comb begin
    beat                = '0;
    beat.result_kind    = KIND_TX;
    beat.transmit_byte  = byte_sel;
    beat.last_of_packet = last;
  end

endmodule

### hdl/scf_deframer.sv
module scf_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  scf_pkg::step_ctl_t  ctl,
  input  logic [7:0]          rx_byte,
  output scf_pkg::out_item_t  report,
  output logic                report_valid
);
  import scf_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] b4_r, b5_r, b6_r, b7_r, b8_r;
  logic       take;

  function automatic logic [4:0] map_error(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] st;
    if (hi == 8'h00)
      st = ST_INVALID;
    else if (lo <= NACK_MAX)
      st = lo[4:0];
    else
      st = ST_UNKNOWN;
    return st;
  endfunction

  // Drop bytes while hunting for sync; within a packet every byte counts
  assign take         = ctl.step_rx && !((pos_r == 4'd0) && (rx_byte != SYNC_BYTE));
  assign report_valid = take && (pos_r == LAST_POS);

  always_comb begin
    pos_nxt = pos_r;
    if (take)
      pos_nxt = (pos_r == LAST_POS) ? 4'd0 : pos_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Only the bytes that feed the report are kept
  always_ff @(posedge clk) begin
    if (take) begin
      case (pos_r)
        4'd4:    b4_r <= rx_byte;
        4'd5:    b5_r <= rx_byte;
        4'd6:    b6_r <= rx_byte;
        4'd7:    b7_r <= rx_byte;
        4'd8:    b8_r <= rx_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    report                = '0;
    report.result_kind    = KIND_REPORT;
    report.last_of_packet = 1'b1;
    report.ack_flag       = (b8_r == ACK_BYTE);
    report.error_status   = report.ack_flag ? ST_NONE : map_error(b5_r, b4_r);
    report.response_param = {b7_r, b6_r, b5_r, b4_r};
  end

endmodule

### hdl/scf_out_skid.sv
module scf_out_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scf_pkg::out_item_t  push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output scf_pkg::out_item_t  out_data
);
  import scf_pkg::*;

  logic      out_valid_r, skid_valid_r;
  out_item_t out_r, skid_r;
  logic      pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control: skid only fills when the output register is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop)
        skid_valid_r <= 1'b0;
    end else if (push) begin
      if (out_valid_r && !pop)
        skid_valid_r <= 1'b1;
      else
        out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop)
        out_r <= skid_r;
    end else if (push) begin
      if (out_valid_r && !pop)
        skid_r <= push_item;
      else
        out_r <= push_item;
    end
  end

endmodule

### hdl/scanner_cmd_framer_resp_deframer_top.sv
// Command framer and response deframer for a fixed 12-byte packet link.
//
// Input channel (in_valid / in_stall / in_data): one beat is either a command
// (opcode 0) or one byte received from the link (opcode 1). Output channel
// (out_valid / out_stall / out_data): transmit bytes and response reports.
// Configuration (cfg_wr_en / cfg_index / cfg_wdata): start bytes and device id;
// write them only while the block is idle. The block itself does not enforce this.
//
// A command expands into twelve transmit beats, one per cycle while the skid
// register is not full: start bytes, device id, parameter, command word and a
// running 16-bit byte sum. It holds the work register until its last beat is pushed.
// A received byte is released from the work register once it is stepped; received
// bytes are taken every cycle while the skid register is not full. The twelfth byte
// of a response frame (started by 0x55) gives one report beat.
// An input beat is registered in the work register, its results in the output register.
// Results go through an output register plus a skid register, so in_stall
// comes from registers only; it is high while a held command has beats left,
// and while held work meets a full skid (receiver stalled, two results waiting).
// Reset (synchronous, rst_n low) empties the pipeline, restores the default
// registers and puts the deframer back into sync hunting.
module scanner_cmd_framer_resp_deframer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  scf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output scf_pkg::out_item_t               out_data,
  input  logic                             cfg_wr_en,
  input  logic [scf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import scf_pkg::*;

  cfg_regs_t cfg_r;
  logic      work_valid_r;
  in_item_t  work_r;
  step_ctl_t ctl;
  logic      emit_ok, work_done, accept;
  logic      skid_full, frm_last, rpt_valid, push;
  out_item_t frm_beat, rpt_beat, push_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_one <= 8'h55;
      cfg_r.start_two <= 8'hAA;
      cfg_r.device_id <= 16'h0001;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_ONE: cfg_r.start_one <= cfg_wdata[7:0];
        REG_START_TWO: cfg_r.start_two <= cfg_wdata[7:0];
        REG_DEVICE_ID: cfg_r.device_id <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Work stage: one item, released when a received byte is stepped or a command's last beat is pushed
  assign emit_ok     = !skid_full;
  assign ctl.step_cmd = work_valid_r && emit_ok && (work_r.opcode == OP_COMMAND);
  assign ctl.step_rx  = work_valid_r && emit_ok && (work_r.opcode == OP_RX_BYTE);
  assign work_done   = ctl.step_rx || (ctl.step_cmd && frm_last);
  assign in_stall    = work_valid_r && !work_done;
  assign accept      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
    end else if (accept) begin
      work_valid_r <= 1'b1;
    end else if (work_done) begin
      work_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)
      work_r <= in_data;
  end

  scf_framer u_framer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cfg   (cfg_r),
    .item  (work_r),
    .beat  (frm_beat),
    .last  (frm_last)
  );

  scf_deframer u_deframer (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .rx_byte      (work_r.received_byte),
    .report       (rpt_beat),
    .report_valid (rpt_valid)
  );

  // Result select into the output stage
  assign push      = ctl.step_cmd || rpt_valid;
  assign push_item = ctl.step_cmd ? frm_beat : rpt_beat;

  scf_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### dv/scf_link_checker.sv
module scf_link_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  scf_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  scf_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             outstanding
);
  import scf_pkg::*;

  // Shadow copy of the configuration registers
  logic [7:0]  start_one;
  logic [7:0]  start_two;
  logic [15:0] dev_id;

  // Shadow deframer state
  logic [3:0]  rx_pos;
  logic [7:0]  rx_frame [12];

  // Beats still owed by the block, oldest first
  out_item_t   pending_beats [$];

  task automatic flag_error(input string what);
    $display("%0t checker: %s", $time, what);
    fail_count++;
  endtask

  function automatic out_item_t tx_beat(input logic [7:0] b, input logic last);
    out_item_t beat;
    beat                = '0;
    beat.result_kind    = KIND_TX;
    beat.transmit_byte  = b;
    beat.last_of_packet = last;
    return beat;
  endfunction

  // Twelve-byte command packet with its 16-bit byte sum
  task automatic frame_command(input logic [7:0] code, input logic [31:0] param);
    logic [7:0]  pkt [12];
    logic [15:0] sum;
    pkt[0] = start_one;
    pkt[1] = start_two;
    pkt[2] = dev_id[7:0];
    pkt[3] = dev_id[15:8];
    pkt[4] = param[7:0];
    pkt[5] = param[15:8];
    pkt[6] = param[23:16];
    pkt[7] = param[31:24];
    pkt[8] = code;
    pkt[9] = 8'h00;
    sum = '0;
    for (int i = 0; i < 10; i++) begin
      sum = sum + 16'(pkt[i]);
    end
    pkt[10] = sum[7:0];
    pkt[11] = sum[15:8];
    for (int i = 0; i < 12; i++) begin
      pending_beats.push_back(tx_beat(pkt[i], i == 11));
    end
  endtask

  // NACK status: high byte zero is invalid, low byte above the table is unknown
  function automatic logic [4:0] nack_status(input logic [7:0] hi, input logic [7:0] lo);
    if (hi == 8'h00) begin
      return ST_INVALID;
    end
    if (lo <= NACK_MAX) begin
      return lo[4:0];
    end
    return ST_UNKNOWN;
  endfunction

  // One received link byte: hunt for sync, collect, report on the twelfth
  task automatic deframe_byte(input logic [7:0] b);
    out_item_t rep;
    if (rx_pos == 4'd0 && b != SYNC_BYTE) begin
      return;
    end
    rx_frame[rx_pos] = b;
    if (rx_pos != LAST_POS) begin
      rx_pos = rx_pos + 4'd1;
      return;
    end
    rx_pos                = 4'd0;
    rep                   = '0;
    rep.result_kind       = KIND_REPORT;
    rep.last_of_packet    = 1'b1;
    rep.ack_flag          = (rx_frame[8] == ACK_BYTE);
    rep.error_status      = rep.ack_flag ? ST_NONE : nack_status(rx_frame[5], rx_frame[4]);
    rep.response_param    = {rx_frame[7], rx_frame[6], rx_frame[5], rx_frame[4]};
    pending_beats.push_back(rep);
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (pending_beats.size() == 0) begin
      flag_error($sformatf("result beat %h with nothing owed", got));
      return;
    end
    want = pending_beats.pop_front();
    if (got.result_kind !== want.result_kind)
      flag_error($sformatf("result_kind %0d, wanted %0d", got.result_kind, want.result_kind));
    if (got.transmit_byte !== want.transmit_byte)
      flag_error($sformatf("transmit_byte %h, wanted %h", got.transmit_byte,
                           want.transmit_byte));
    if (got.last_of_packet !== want.last_of_packet)
      flag_error($sformatf("last_of_packet %0d, wanted %0d", got.last_of_packet,
                           want.last_of_packet));
    if (got.ack_flag !== want.ack_flag)
      flag_error($sformatf("ack_flag %0d, wanted %0d", got.ack_flag, want.ack_flag));
    if (got.error_status !== want.error_status)
      flag_error($sformatf("error_status %0d, wanted %0d", got.error_status,
                           want.error_status));
    if (got.response_param !== want.response_param)
      flag_error($sformatf("response_param %h, wanted %h", got.response_param,
                           want.response_param));
  endtask

  // Watch all three ports at each edge: results first, then new work
  always @(posedge clk) begin
    if (!rst_n) begin
      start_one  = 8'h55;
      start_two  = 8'hAA;
      dev_id     = 16'h0001;
      rx_pos     = 4'd0;
      fail_count = 0;
      pending_beats.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_START_ONE: start_one = cfg_wdata[7:0];
          REG_START_TWO: start_two = cfg_wdata[7:0];
          REG_DEVICE_ID: dev_id    = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        check_beat(out_data);
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_COMMAND) begin
          frame_command(in_data.command_code, in_data.command_param);
        end else begin
          deframe_byte(in_data.received_byte);
        end
      end
    end
    outstanding <= pending_beats.size();
  end

endmodule

### dv/tb_top.sv
module tb_top;
  import scf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 270;
  localparam int RAND_FRAMES = 15;
  localparam int PHASES      = 5;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   frames_sent = 0;
  logic idle_on     = 1'b1;

  scanner_cmd_framer_resp_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  scf_link_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver back-pressure in short random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One input beat; may leave a short gap after it
  task automatic send_beat(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_command(input logic [7:0] code, input logic [31:0] param);
    in_item_t item;
    item.opcode        = OP_COMMAND;
    item.command_code  = code;
    item.command_param = param;
    item.received_byte = 8'($urandom);
    send_beat(item);
  endtask

  task automatic send_rx(input logic [7:0] b);
    in_item_t item;
    item.opcode        = OP_RX_BYTE;
    item.command_code  = 8'($urandom);
    item.command_param = $urandom;
    item.received_byte = b;
    send_beat(item);
  endtask

  // Whole response frame; a broken one carries plain random bytes.
  // Sometimes a command is slipped in part way through.
  task automatic send_response(input bit broken);
    logic [7:0] fr [12];
    int         pick;
    int         cut;
    fr[0] = SYNC_BYTE;
    for (int i = 1; i < 12; i++) begin
      fr[i] = 8'($urandom);
    end
    if (!broken) begin
      pick = $urandom_range(0, 9);
      if (pick < 2)
        fr[4] = 8'h00;
      else if (pick < 6)
        fr[4] = 8'($urandom_range(1, NACK_MAX));
      else
        fr[4] = 8'($urandom_range(NACK_MAX + 1, 255));
      if ($urandom_range(0, 3) == 0) fr[5] = 8'h00;
      if ($urandom_range(0, 2) == 0) fr[8] = ACK_BYTE;
      if ($urandom_range(0, 3) == 0) fr[$urandom_range(1, 11)] = SYNC_BYTE;
    end
    cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 10) : -1;
    for (int i = 0; i < 12; i++) begin
      send_rx(fr[i]);
      if (i == cut) send_command(8'($urandom), $urandom);
    end
    frames_sent++;
  endtask

  // Line noise between frames, never the sync byte
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      b = 8'($urandom);
      if (b == SYNC_BYTE) b = ~b;
      send_rx(b);
    end
  endtask

  // Register writes back to back; the spare index must be ignored
  task automatic write_regs(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [15:0] id);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_START_ONE;
    cfg_wdata <= {8'($urandom), s1};
    @(posedge clk);
    cfg_index <= REG_START_TWO;
    cfg_wdata <= {8'($urandom), s2};
    @(posedge clk);
    cfg_index <= REG_DEVICE_ID;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_index <= CFG_IDX_W'(3);
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait for every owed beat, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [95:0] ack_frame;
    int          r;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, dropped bytes while hunting, an ACK frame
    // with sync bytes as data and a command arriving mid-frame
    send_command(8'h00, 32'h0000_0000);
    send_command(8'hFF, 32'hFFFF_FFFF);
    send_rx(8'h00);
    send_rx(8'hFF);
    ack_frame = 96'h55_01_55_FF_FF_01_55_AA_30_00_55_FF;
    for (int i = 0; i < 12; i++) begin
      send_rx(ack_frame[95 - 8*i -: 8]);
      if (i == 5) send_command(8'h5A, 32'h1234_5678);
    end
    frames_sent++;
    drain();

    // Random phases under differing register settings; last one at full rate
    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1:       write_regs(8'h00, 8'h00, 16'h0000);
        2:       write_regs(8'hFF, 8'hFF, 16'hFFFF);
        PHASES:  write_regs(8'h55, 8'hAA, 16'h0001);
        default: write_regs(8'($urandom), 8'($urandom), 16'($urandom));
      endcase
      idle_on = (p != PHASES);
      while (items_sent < 17 + RAND_ITEMS * p / PHASES ||
             frames_sent < 1 + RAND_FRAMES * p / PHASES) begin
        r = $urandom_range(0, 9);
        if (r < 6)
          send_response(1'b0);
        else if (r == 6)
          send_response(1'b1);
        else if (r < 9)
          send_command(8'($urandom), $urandom);
        else
          send_noise();
      end
      drain();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
